/* design/ffha_pkg.sv */
// Shared types and constants for the first-fit heap allocator.
`default_nettype none
package ffha_pkg;
  localparam int unsigned HEAP_BYTES_DEF   = 1048576;
  localparam int unsigned HEADER_BYTES_DEF = 16;
  localparam int unsigned PAGE_BYTES_DEF   = 4096;
  localparam int unsigned MAX_CHUNKS_DEF   = 256;

  localparam int OFF_W  = 20;
  localparam int SIZE_W = 21;
  localparam int ST_W   = 3;
  localparam int TOP_W  = 8;

  localparam logic [ST_W-1:0] ST_OK      = 3'd0;
  localparam logic [ST_W-1:0] ST_NULL    = 3'd1;
  localparam logic [ST_W-1:0] ST_OOM     = 3'd2;
  localparam logic [ST_W-1:0] ST_FULL    = 3'd3;
  localparam logic [ST_W-1:0] ST_UNKNOWN = 3'd4;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // One chunk slot as held in the table memory.
  typedef struct packed {
    logic [OFF_W-1:0]  offset;
    logic [SIZE_W-1:0] size;
    logic              used;
  } slot_t;
endpackage
`default_nettype wire

/* design/first_fit_heap_allocator_top.sv */
// Top level of the first-fit heap allocator: sequencer around the chunk table memory.
// A request scans the chunk table slot by slot; a split or merge then moves the slots
// that follow the found slot, one read and one write per slot moved.
// Throughput: one request at a time; the next is accepted once the result is registered,
// and a result still waiting for the receiver holds the block until it is taken.
// The table memory has a registered read port: the scan reads one slot per cycle and
// each shift step is a read followed by a write. Reset clears the chunk count and heap top.
`default_nettype none
module first_fit_heap_allocator_top
  import ffha_pkg::*;
#(
  parameter int unsigned HEAP_BYTES   = HEAP_BYTES_DEF,
  parameter int unsigned HEADER_BYTES = HEADER_BYTES_DEF,
  parameter int unsigned PAGE_BYTES   = PAGE_BYTES_DEF,
  parameter int unsigned MAX_CHUNKS   = MAX_CHUNKS_DEF
) (
  input  wire  logic        clk,
  input  wire  logic        rst_n,
  input  wire  logic        in_tvalid,
  output logic              in_tready,
  input  wire  logic [47:0] in_tdata,  // operation, request_size[20:0], address[19:0], zero fill
  output logic              out_tvalid,
  input  wire  logic        out_tready,
  output logic [31:0]       out_tdata  // payload_offset[19:0], status[2:0], heap_top_pages[7:0], zero
);
  localparam int IDX_W = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
  localparam int CNT_W = $clog2(MAX_CHUNKS + 1);
  localparam int PG_SH = $clog2(PAGE_BYTES);
  localparam int WIDE  = 34;
  localparam logic [CNT_W-1:0] MAXC = CNT_W'(MAX_CHUNKS);
  localparam logic [WIDE-1:0] HDRW = WIDE'(HEADER_BYTES);
  localparam logic [WIDE-1:0] HEAPW = WIDE'(HEAP_BYTES);

  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_SCAN   = 13'b0000000000010,
    S_CHECK  = 13'b0000000000100,
    S_SHUPR  = 13'b0000000001000,
    S_SHUPW  = 13'b0000000010000,
    S_SPLIT  = 13'b0000000100000,
    S_FPREV  = 13'b0000001000000,
    S_FPREVW = 13'b0000010000000,
    S_FNEXT  = 13'b0000100000000,
    S_FNEXTW = 13'b0001000000000,
    S_SHDNR  = 13'b0010000000000,
    S_SHDNW  = 13'b0100000000000,
    S_DONE   = 13'b1000000000000
  } state_t;

  state_t state_r, state_nxt;

  // Chunk table memory.
  slot_t mem [MAX_CHUNKS];
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr, mem_raddr;
  slot_t            mem_wdata, mem_rdata;
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    mem_rdata <= mem[mem_raddr];
  end

  logic [CNT_W-1:0] count_r, count_nxt;
  logic [TOP_W-1:0] top_r, top_nxt;
  logic             op_r, op_nxt;
  logic [SIZE_W-1:0] req_r, req_nxt;
  logic [OFF_W-1:0]  addr_r, addr_nxt;
  logic [CNT_W-1:0]  i_r, i_nxt;       // scan position / shift position
  logic [CNT_W-1:0]  pos_r, pos_nxt;   // found slot
  logic              rdv_r, rdv_nxt;   // a read issued last cycle is valid now
  slot_t             cur_r, cur_nxt;   // found slot contents
  slot_t             last_r, last_nxt; // last slot seen by the scan
  slot_t             hold_r, hold_nxt; // slot carried by a shift
  logic              found_r, found_nxt;
  logic [OFF_W-1:0]  res_off_r, res_off_nxt;
  logic [ST_W-1:0]   res_st_r, res_st_nxt;
  logic              ov_r, ov_nxt;
  logic [OFF_W-1:0]  o_off_r, o_off_nxt;
  logic [ST_W-1:0]   o_st_r, o_st_nxt;
  logic [TOP_W-1:0]  o_top_r, o_top_nxt;
  logic [CNT_W-1:0]  cnt_dn_r, cnt_dn_nxt; // slot to remove during a down shift

  logic [WIDE-1:0] need_w, end_w, newtop_w, fit_rest;
  always_comb begin
    need_w   = WIDE'(req_r) + HDRW;
    end_w    = WIDE'(last_r.offset) + WIDE'(last_r.size) + need_w;
    if (count_r == '0) end_w = need_w;
    if (end_w > (WIDE'(top_r) << PG_SH))
      newtop_w = (end_w + WIDE'(PAGE_BYTES - 1)) >> PG_SH;
    else
      newtop_w = WIDE'(top_r);
    fit_rest = WIDE'(cur_r.size) - need_w;
  end

  assign in_tready = (state_r == S_IDLE);
  wire in_fire  = in_tvalid && in_tready;
  wire out_fire = out_tvalid && out_tready;

  always_comb begin
    state_nxt = state_r; count_nxt = count_r; top_nxt = top_r;
    op_nxt = op_r; req_nxt = req_r; addr_nxt = addr_r;
    i_nxt = i_r; pos_nxt = pos_r; rdv_nxt = 1'b0;
    cur_nxt = cur_r; last_nxt = last_r; hold_nxt = hold_r; found_nxt = found_r;
    res_off_nxt = res_off_r; res_st_nxt = res_st_r;
    ov_nxt = ov_r; o_off_nxt = o_off_r; o_st_nxt = o_st_r; o_top_nxt = o_top_r;
    cnt_dn_nxt = cnt_dn_r;
    mem_we = 1'b0; mem_waddr = '0; mem_wdata = '0; mem_raddr = '0;
    if (out_fire) ov_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          op_nxt = in_tdata[0];
          req_nxt = in_tdata[21:1];
          addr_nxt = in_tdata[41:22];
          i_nxt = '0; found_nxt = 1'b0;
          res_off_nxt = '0;
          if ((in_tdata[0] == OP_ALLOC && in_tdata[21:1] == '0) ||
              (in_tdata[0] == OP_FREE && in_tdata[41:22] == '0)) begin
            res_st_nxt = ST_NULL; state_nxt = S_DONE;
          end else state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        // Pipelined scan: read slot i, examine slot i-1.
        logic hit;
        hit = 1'b0;
        if (rdv_r) begin
          last_nxt = mem_rdata;
          if (op_r == OP_ALLOC)
            hit = !mem_rdata.used && (WIDE'(mem_rdata.size) >= need_w);
          else
            hit = (WIDE'(mem_rdata.offset) + HDRW) == WIDE'(addr_r);
        end
        if (hit) begin
          found_nxt = 1'b1; cur_nxt = mem_rdata; pos_nxt = i_r - 1'b1;
          state_nxt = S_CHECK;
        end else if (i_r < count_r) begin
          mem_raddr = i_r[IDX_W-1:0]; rdv_nxt = 1'b1; i_nxt = i_r + 1'b1;
        end else if (!rdv_r || !hit) begin
          if (!rdv_r || i_r == count_r) state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (op_r == OP_ALLOC) begin
          if (found_r) begin
            res_st_nxt = ST_OK;
            res_off_nxt = OFF_W'(WIDE'(cur_r.offset) + HDRW);
            if (fit_rest > HDRW && count_r < MAXC) begin
              // Split: write used head, then open a gap at pos+1.
              mem_we = 1'b1; mem_waddr = pos_r[IDX_W-1:0];
              mem_wdata = '{offset: cur_r.offset, size: SIZE_W'(need_w), used: 1'b1};
              hold_nxt = '{offset: OFF_W'(WIDE'(cur_r.offset) + need_w),
                           size: SIZE_W'(fit_rest), used: 1'b0};
              i_nxt = pos_r + 1'b1;
              state_nxt = (pos_r + 1'b1 == count_r) ? S_SPLIT : S_SHUPR;
            end else begin
              mem_we = 1'b1; mem_waddr = pos_r[IDX_W-1:0];
              mem_wdata = cur_r; mem_wdata.used = 1'b1;
              state_nxt = S_DONE;
            end
          end else if (count_r >= MAXC) begin
            res_st_nxt = ST_FULL; state_nxt = S_DONE;
          end else if ((newtop_w << PG_SH) >= HEAPW) begin
            res_st_nxt = ST_OOM; state_nxt = S_DONE;
          end else begin
            top_nxt = TOP_W'(newtop_w);
            mem_we = 1'b1; mem_waddr = count_r[IDX_W-1:0];
            mem_wdata = '{offset: OFF_W'(end_w - need_w), size: SIZE_W'(need_w),
                          used: 1'b1};
            count_nxt = count_r + 1'b1;
            res_st_nxt = ST_OK; res_off_nxt = OFF_W'(end_w - need_w + HDRW);
            state_nxt = S_DONE;
          end
        end else begin
          if (!found_r) begin
            res_st_nxt = ST_UNKNOWN; state_nxt = S_DONE;
          end else begin
            res_st_nxt = ST_OK;
            cur_nxt.used = 1'b0;
            if (pos_r != '0) begin
              mem_raddr = IDX_W'(pos_r - 1'b1); state_nxt = S_FPREV;
            end else begin
              // The first slot has no neighbor before it.
              cnt_dn_nxt = MAXC; state_nxt = S_FPREVW;
            end
          end
        end
      end
      S_SHUPR: begin
        // Insert hold at i, carry displaced slot onward.
        mem_raddr = i_r[IDX_W-1:0]; state_nxt = S_SHUPW;
      end
      S_SHUPW: begin
        mem_we = 1'b1; mem_waddr = i_r[IDX_W-1:0]; mem_wdata = hold_r;
        hold_nxt = mem_rdata; i_nxt = i_r + 1'b1;
        state_nxt = (i_r + 1'b1 == count_r) ? S_SPLIT : S_SHUPR;
      end
      S_SPLIT: begin
        mem_we = 1'b1; mem_waddr = i_r[IDX_W-1:0]; mem_wdata = hold_r;
        count_nxt = count_r + 1'b1; state_nxt = S_DONE;
      end
      S_FPREV: begin
        if (!mem_rdata.used) begin
          cur_nxt.offset = mem_rdata.offset;
          cur_nxt.size = mem_rdata.size + cur_r.size;
          cnt_dn_nxt = pos_r; pos_nxt = pos_r - 1'b1;
        end else cnt_dn_nxt = '0;
        state_nxt = S_FPREVW;
        // flag no removal with marker equal to MAXC when unmerged; pos>0 here
        if (mem_rdata.used) cnt_dn_nxt = MAXC;
      end
      S_FPREVW: begin
        if (pos_r + 1'b1 < count_r - ((cnt_dn_r != MAXC && state_r == S_FPREVW
            && cnt_dn_r != '0) ? 1'b1 : 1'b0)) begin
          mem_raddr = IDX_W'(cnt_dn_r != MAXC && cnt_dn_r != '0 ? pos_r + 2'd2
                                                               : pos_r + 1'b1);
          state_nxt = S_FNEXT;
        end else state_nxt = S_FNEXTW;
        hold_nxt.used = 1'b0;
      end
      S_FNEXT: begin
        if (!mem_rdata.used) begin
          cur_nxt.size = cur_r.size + mem_rdata.size;
          hold_nxt.used = 1'b1;
        end
        state_nxt = S_FNEXTW;
      end
      S_FNEXTW: begin
        // Write merged chunk, then remove absorbed slots by shifting down.
        mem_we = 1'b1; mem_waddr = pos_r[IDX_W-1:0]; mem_wdata = cur_r;
        begin
          logic [1:0] nrm;
          nrm = 2'((cnt_dn_r != MAXC && cnt_dn_r != '0) ? 1 : 0) + 2'(hold_r.used);
          if (nrm == 2'd0) state_nxt = S_DONE;
          else begin
            count_nxt = count_r - CNT_W'(nrm);
            i_nxt = pos_r + 1'b1;
            cnt_dn_nxt = CNT_W'(nrm);
            state_nxt = (pos_r + 1'b1 >= count_r - CNT_W'(nrm)) ? S_DONE : S_SHDNR;
          end
        end
      end
      S_SHDNR: begin
        mem_raddr = IDX_W'(i_r + cnt_dn_r); state_nxt = S_SHDNW;
      end
      S_SHDNW: begin
        mem_we = 1'b1; mem_waddr = i_r[IDX_W-1:0]; mem_wdata = mem_rdata;
        i_nxt = i_r + 1'b1;
        state_nxt = (i_r + 1'b1 >= count_r) ? S_DONE : S_SHDNR;
      end
      S_DONE: begin
        if (!ov_r || out_fire) begin
          ov_nxt = 1'b1; o_off_nxt = res_off_r; o_st_nxt = res_st_r;
          o_top_nxt = top_r; state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; count_r <= '0; top_r <= '0; ov_r <= 1'b0; rdv_r <= 1'b0;
    end else begin
      state_r <= state_nxt; count_r <= count_nxt; top_r <= top_nxt;
      ov_r <= ov_nxt; rdv_r <= rdv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r <= op_nxt; req_r <= req_nxt; addr_r <= addr_nxt; i_r <= i_nxt;
    pos_r <= pos_nxt; cur_r <= cur_nxt; last_r <= last_nxt; hold_r <= hold_nxt;
    found_r <= found_nxt; res_off_r <= res_off_nxt; res_st_r <= res_st_nxt;
    o_off_r <= o_off_nxt; o_st_r <= o_st_nxt; o_top_r <= o_top_nxt;
    cnt_dn_r <= cnt_dn_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {1'b0, o_top_r, o_st_r, o_off_r};

`ifndef NO_ASSERTIONS
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n) count_r <= MAXC)
    else $error("chunk count above table size");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_tready) else $error("request taken while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("result dropped");
  a_top_mono: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> top_r >= $past(top_r)) else $error("heap top shrank");
`endif
endmodule
`default_nettype wire

/* tb/tb_first_fit_heap_allocator_checker.sv */
// Checker for the first-fit heap allocator: chunk table predictor and result comparison.
`timescale 1ns / 1ps
`default_nettype none
module tb_first_fit_heap_allocator_checker
  import ffha_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [47:0] in_tdata,
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [31:0] out_tdata,
  output int               fail_count,
  output int               pending
);
  typedef struct packed {
    logic [OFF_W-1:0] payload;
    logic [ST_W-1:0]  status;
    logic [TOP_W-1:0] top_pages;
  } heap_result_t;

  int unsigned chunk_off  [MAX_CHUNKS_DEF];
  int unsigned chunk_size [MAX_CHUNKS_DEF];
  bit          chunk_used [MAX_CHUNKS_DEF];
  int unsigned chunk_cnt;
  int unsigned heap_pages;

  heap_result_t expected_results[$];

  assign pending = expected_results.size();

  function automatic void shift_up(input int unsigned pos);
    for (int unsigned k = chunk_cnt; k > pos; k--) begin
      chunk_off[k]  = chunk_off[k-1];
      chunk_size[k] = chunk_size[k-1];
      chunk_used[k] = chunk_used[k-1];
    end
    chunk_cnt++;
  endfunction

  function automatic void shift_down(input int unsigned pos);
    for (int unsigned k = pos; k + 1 < chunk_cnt; k++) begin
      chunk_off[k]  = chunk_off[k+1];
      chunk_size[k] = chunk_size[k+1];
      chunk_used[k] = chunk_used[k+1];
    end
    chunk_cnt--;
  endfunction

  function automatic logic [ST_W-1:0] alloc_chunk(input int unsigned req,
                                                  output int unsigned payload);
    int unsigned need;
    int unsigned rest;
    int unsigned off;
    int unsigned pages;
    longint unsigned end_byte;
    need = req + HEADER_BYTES_DEF;
    payload = 0;
    if (req == 0) return ST_NULL;
    for (int unsigned i = 0; i < chunk_cnt; i++) begin
      if (!chunk_used[i] && chunk_size[i] >= need) begin
        rest = chunk_size[i] - need;
        if (rest > HEADER_BYTES_DEF && chunk_cnt < MAX_CHUNKS_DEF) begin
          shift_up(i + 1);
          chunk_off[i+1]  = chunk_off[i] + need;
          chunk_size[i+1] = rest;
          chunk_used[i+1] = 1'b0;
          chunk_size[i]   = need;
        end
        chunk_used[i] = 1'b1;
        payload = chunk_off[i] + HEADER_BYTES_DEF;
        return ST_OK;
      end
    end
    if (chunk_cnt >= MAX_CHUNKS_DEF) return ST_FULL;
    off = (chunk_cnt > 0) ? chunk_off[chunk_cnt-1] + chunk_size[chunk_cnt-1] : 0;
    end_byte = longint'(off) + need;
    pages = heap_pages;
    if (end_byte > longint'(pages) * PAGE_BYTES_DEF)
      pages = int'((end_byte + PAGE_BYTES_DEF - 1) / PAGE_BYTES_DEF);
    if (longint'(pages) * PAGE_BYTES_DEF >= HEAP_BYTES_DEF) return ST_OOM;
    heap_pages = pages;
    chunk_off[chunk_cnt]  = off;
    chunk_size[chunk_cnt] = need;
    chunk_used[chunk_cnt] = 1'b1;
    chunk_cnt++;
    payload = off + HEADER_BYTES_DEF;
    return ST_OK;
  endfunction

  function automatic logic [ST_W-1:0] free_chunk(input int unsigned addr);
    int unsigned i;
    if (addr == 0) return ST_NULL;
    for (i = 0; i < chunk_cnt; i++)
      if (chunk_off[i] + HEADER_BYTES_DEF == addr) break;
    if (i >= chunk_cnt) return ST_UNKNOWN;
    chunk_used[i] = 1'b0;
    if (i > 0 && !chunk_used[i-1]) begin
      chunk_size[i-1] += chunk_size[i];
      shift_down(i);
      i--;
    end
    if (i + 1 < chunk_cnt && !chunk_used[i+1]) begin
      chunk_size[i] += chunk_size[i+1];
      shift_down(i + 1);
    end
    return ST_OK;
  endfunction

  always @(posedge clk) begin
    heap_result_t got;
    heap_result_t want;
    heap_result_t pred;
    int unsigned  payload;
    if (!rst_n) begin
      chunk_cnt  = 0;
      heap_pages = 0;
      fail_count <= 0;
      expected_results.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got.payload   = out_tdata[19:0];
        got.status    = out_tdata[22:20];
        got.top_pages = out_tdata[30:23];
        if (expected_results.size() == 0) begin
          $error("result with no request outstanding: %h", out_tdata);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_results.pop_front();
          if (got.payload !== want.payload)
            $error("payload_offset expected %0d actual %0d", want.payload, got.payload);
          if (got.status !== want.status)
            $error("status expected %0d actual %0d", want.status, got.status);
          if (got.top_pages !== want.top_pages)
            $error("heap_top_pages expected %0d actual %0d", want.top_pages, got.top_pages);
          if (got !== want) fail_count <= fail_count + 1;
        end
      end
      if (in_tvalid && in_tready) begin
        payload = 0;
        if (in_tdata[0] == OP_ALLOC)
          pred.status = alloc_chunk(in_tdata[21:1], payload);
        else
          pred.status = free_chunk(in_tdata[41:22]);
        pred.payload   = payload[19:0];
        pred.top_pages = heap_pages[7:0];
        expected_results.push_back(pred);
      end
    end
  end
endmodule
`default_nettype wire

/* tb/tb_first_fit_heap_allocator_top.sv */
// Testbench top for the first-fit heap allocator: request stimulus and verdict.
`timescale 1ns / 1ps
`default_nettype none
module tb_first_fit_heap_allocator_top;
  import ffha_pkg::*;

  localparam int CYCLE_LIMIT = 4000000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  int          fail_count;
  int          pending;
  int          cycles = 0;
  int          results_seen = 0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;
  int unsigned live_addrs[$];

  always #4 clk = ~clk;

  first_fit_heap_allocator_top u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  tb_first_fit_heap_allocator_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .fail_count(fail_count), .pending(pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // Receiver: random stalls, plus one long hold-off so the block backs up.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        results_seen <= results_seen + 1;
        if (out_tdata[22:20] == ST_OK && out_tdata[19:0] != 0)
          live_addrs.push_back(out_tdata[19:0]);
      end
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left <= hold_left - 1;
      end else if (!hold_done && results_seen == 40) begin
        out_tready <= 1'b0;
        hold_left <= 3000;
        hold_done <= 1'b1;
      end else if (cycles % 2000 < 400) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= (pick_gap() == 0);
      end
    end
  end

  task automatic send_request(input logic op, input int unsigned size,
                              input int unsigned addr);
    int gap;
    gap = (cycles % 3000 < 500) ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'b0, addr[19:0], size[20:0], op};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_random(input int free_pct);
    int r;
    int idx;
    r = $urandom_range(99);
    if (r < free_pct) begin
      if (live_addrs.size() > 0 && $urandom_range(9) > 0) begin
        idx = $urandom_range(live_addrs.size() - 1);
        send_request(OP_FREE, $urandom_range(1048576), live_addrs[idx]);
        // Occasionally keep the address so that a later free hits a free chunk.
        if ($urandom_range(7) > 0) live_addrs.delete(idx);
      end else begin
        send_request(OP_FREE, $urandom_range(1048576), $urandom_range(1048575));
      end
    end else if (r < free_pct + 4) begin
      if ($urandom_range(1)) send_request(OP_ALLOC, 0, $urandom_range(1048575));
      else send_request(OP_FREE, $urandom_range(1048576), 0);
    end else begin
      r = $urandom_range(99);
      if (r < 75) send_request(OP_ALLOC, $urandom_range(256, 1), $urandom_range(1048575));
      else if (r < 95) send_request(OP_ALLOC, $urandom_range(65536, 1), 0);
      else send_request(OP_ALLOC, $urandom_range(1048576, 1), 0);
    end
  endtask

  initial begin
    int waited;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_request(OP_ALLOC, 0, 0);
    send_request(OP_FREE, 0, 0);
    send_request(OP_FREE, 0, 12345);
    send_request(OP_ALLOC, 100, 0);
    send_request(OP_ALLOC, 4000, 0);
    send_request(OP_ALLOC, 50, 0);
    send_request(OP_FREE, 0, 16);
    send_request(OP_FREE, 0, 16);
    send_request(OP_ALLOC, 20, 0);
    send_request(OP_ALLOC, 1048576, 0);
    send_request(OP_ALLOC, 2097151, 1048575);
    send_request(OP_ALLOC, 900000, 0);
    send_request(OP_ALLOC, 200000, 0);
    send_request(OP_FREE, 0, 132);
    send_request(OP_FREE, 0, 4148);
    send_request(OP_FREE, 0, 1048575);
    send_request(OP_ALLOC, 1, 0);
    send_request(OP_ALLOC, 65536, 0);

    for (int n = 0; n < 130; n++) send_random(40);
    // Many small allocations drive the chunk table to full.
    for (int n = 0; n < 260; n++) send_request(OP_ALLOC, $urandom_range(40, 1), 0);
    for (int n = 0; n < 140; n++) send_random(60);
    in_tvalid <= 1'b0;

    waited = 0;
    while (pending != 0 && waited < 200000) begin
      @(posedge clk);
      waited++;
    end
    repeat (1100) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
`default_nettype wire

/* files.f */
design/ffha_pkg.sv
design/first_fit_heap_allocator_top.sv
tb/tb_first_fit_heap_allocator_checker.sv
tb/tb_first_fit_heap_allocator_top.sv
